### rtl/bqdi_pkg.sv
package bqdi_pkg;

   localparam int SLOT_COUNT_DEF = 1024;
   localparam int KEY_COUNT_DEF  = 64;
   localparam int VERTEX_IDS_DEF = 1024;

   localparam logic [5:0] KEY_LIMIT_RESET = 6'd63;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_NEXT   = 2'd1,
      OP_GET    = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_GIVEN    = 2'd0,
      STS_NONE     = 2'd1,
      STS_INSERTED = 2'd2,
      STS_REJECTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OUT_NONE   = 2'd0,
      OUT_INSERT = 2'd1,
      OUT_CURSOR = 2'd2,
      OUT_LOOKUP = 2'd3
   } out_sel_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic        latch;        // capture the request fields
      logic        clr;          // clear one placed flag
      logic        vtx_rd;       // read the per-vertex stores
      logic        bkt_rd_key;   // read bucket store at the request key
      logic        bkt_rd_scan;  // read bucket store at the cursor bucket
      logic        ins_commit;   // perform the insert unless rejected
      logic        prev_rd;      // read the older-neighbor link of the cursor slot
      logic        prev_load;    // move cursor slot to that neighbor, read its vertex
      logic        scan_load;    // place cursor on newest entry of cursor bucket
      logic        cur_rd;       // read the vertex of the cursor slot
      logic        step;         // cursor index minus one
      logic        bucket_dec;   // cursor bucket minus one
      logic        kill;         // cursor exhausted
      logic        out_load;     // load the result register
      out_sel_type out_sel;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic blocked;
      logic idx_zero;
      logic bucket_zero;
      logic below_thr;
      logic nonempty;
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage

### rtl/bqdi_req_if.sv
interface bqdi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [9:0] vertex_id;
   logic [5:0] key;
   logic [5:0] threshold;

   modport source (output valid, operation, vertex_id, key, threshold, input ready);
   modport sink (input valid, operation, vertex_id, key, threshold, output ready);
endinterface

### rtl/bqdi_rsp_if.sv
interface bqdi_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] found_vertex;
   logic [5:0] bucket;
   logic [9:0] position;

   modport source (output valid, status, found_vertex, bucket, position, input ready);
   modport sink (input valid, status, found_vertex, bucket, position, output ready);
endinterface

### rtl/bqdi_ctrl.sv
module bqdi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   output logic              req_ready,
   input  bqdi_pkg::sts_type sts,
   output bqdi_pkg::cmd_type cmd
);

   typedef enum logic [11:0] {
      S_CLEAR   = 12'b0000_0000_0001,
      S_IDLE    = 12'b0000_0000_0010,
      S_INS_RD  = 12'b0000_0000_0100,
      S_INS_WR  = 12'b0000_0000_1000,
      S_NEXT    = 12'b0000_0001_0000,
      S_PREV    = 12'b0000_0010_0000,
      S_SCAN    = 12'b0000_0100_0000,
      S_SCAN_RD = 12'b0000_1000_0000,
      S_GET     = 12'b0001_0000_0000,
      S_EMIT    = 12'b0010_0000_0000,
      S_LOOK    = 12'b0100_0000_0000,
      S_LOOK_RD = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.out_sel = bqdi_pkg::OUT_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (bqdi_pkg::op_type'(req_operation))
                  bqdi_pkg::OP_INSERT: state_in = S_INS_RD;
                  bqdi_pkg::OP_NEXT:   state_in = S_NEXT;
                  bqdi_pkg::OP_GET:    state_in = S_GET;
                  default:             state_in = S_LOOK;
               endcase
            end
         end
         S_INS_RD: begin
            cmd.vtx_rd = 1'b1;
            cmd.bkt_rd_key = 1'b1;
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            if (sts.out_free) begin
               cmd.ins_commit = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_sel = bqdi_pkg::OUT_INSERT;
               state_in = S_IDLE;
            end
         end
         S_NEXT: begin
            if (sts.blocked) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (!sts.idx_zero) begin
               cmd.step = 1'b1;
               cmd.prev_rd = 1'b1;
               state_in = S_PREV;
            end else if (sts.bucket_zero) begin
               if (sts.out_free) begin
                  cmd.kill = 1'b1;
                  cmd.out_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.bucket_dec = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_PREV: begin
            cmd.prev_load = 1'b1;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (sts.below_thr || (!sts.nonempty && sts.bucket_zero)) begin
               if (sts.out_free) begin
                  cmd.kill = 1'b1;
                  cmd.out_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (sts.nonempty) begin
               cmd.bkt_rd_scan = 1'b1;
               state_in = S_SCAN_RD;
            end else begin
               cmd.bucket_dec = 1'b1;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_load = 1'b1;
            state_in = S_EMIT;
         end
         S_GET: begin
            if (sts.blocked) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.cur_rd = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel = bqdi_pkg::OUT_CURSOR;
               state_in = S_IDLE;
            end
         end
         S_LOOK: begin
            cmd.vtx_rd = 1'b1;
            state_in = S_LOOK_RD;
         end
         S_LOOK_RD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel = bqdi_pkg::OUT_LOOKUP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/bqdi_dp.sv
module bqdi_dp #(
   parameter int SLOT_COUNT = bqdi_pkg::SLOT_COUNT_DEF,
   parameter int KEY_COUNT  = bqdi_pkg::KEY_COUNT_DEF,
   parameter int VERTEX_IDS = bqdi_pkg::VERTEX_IDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bqdi_pkg::cmd_type cmd,
   output bqdi_pkg::sts_type sts,
   input  logic [5:0]        key_limit,
   input  logic [9:0]        req_vertex_id,
   input  logic [5:0]        req_key,
   input  logic [5:0]        req_threshold,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [9:0]        rsp_found_vertex,
   output logic [5:0]        rsp_bucket,
   output logic [9:0]        rsp_position
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int KW = $clog2(KEY_COUNT);
   localparam int VW = $clog2(VERTEX_IDS);

   // Request fields.
   logic [9:0] vid_ff;
   logic [5:0] key_ff;
   logic [5:0] thr_ff;

   // Control state.
   logic [VW-1:0]        clr_ff, clr_in;
   logic [SW:0]          used_ff, used_in;
   logic [KEY_COUNT-1:0] bv_ff, bv_in;
   logic                 top_valid_ff, top_valid_in;
   logic [KW-1:0]        top_key_ff, top_key_in;
   logic [SW:0]          top_size_ff, top_size_in;
   logic [SW-1:0]        top_tail_ff, top_tail_in;
   logic                 live_ff, live_in;
   logic [KW-1:0]        cb_ff, cb_in;
   logic [SW-1:0]        ci_ff, ci_in;
   logic [SW-1:0]        cs_ff, cs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [9:0]           rsp_vertex_ff, rsp_vertex_in;
   logic [5:0]           rsp_bucket_ff, rsp_bucket_in;
   logic [9:0]           rsp_position_ff, rsp_position_in;

   // Memories and their registered read data.
   logic          vp_mem [VERTEX_IDS];
   logic [KW-1:0] vi_bkt_mem [VERTEX_IDS];
   logic [SW-1:0] vi_pos_mem [VERTEX_IDS];
   logic [SW:0]   bm_size_mem [KEY_COUNT];
   logic [SW-1:0] bm_tail_mem [KEY_COUNT];
   logic [9:0]    sv_mem [SLOT_COUNT];
   logic [SW-1:0] sp_mem [SLOT_COUNT];

   logic          vp_rd_ff;
   logic [KW-1:0] vi_bkt_rd_ff;
   logic [SW-1:0] vi_pos_rd_ff;
   logic [SW:0]   bm_size_rd_ff;
   logic [SW-1:0] bm_tail_rd_ff;
   logic [9:0]    sv_rd_ff;
   logic [SW-1:0] sp_rd_ff;

   logic [KW-1:0] kidx;
   logic [VW-1:0] vidx;
   logic          kvalid;
   logic          vid_in_range;
   logic          reject;
   logic          commit;
   logic [SW-1:0] pos;
   logic [SW:0]   new_size;
   logic [SW-1:0] slot;
   logic          new_top;
   logic [KW-1:0] bkt_addr;
   logic [SW-1:0] sv_addr;
   logic          sv_re;

   assign kidx = KW'(key_ff);
   assign vidx = VW'(vid_ff);
   assign kvalid = bv_ff[kidx];
   assign vid_in_range = 32'(vid_ff) < 32'(VERTEX_IDS);
   assign reject = (key_ff > key_limit) || (32'(key_ff) >= 32'(KEY_COUNT)) ||
                   !vid_in_range || vp_rd_ff || (used_ff == (SW+1)'(SLOT_COUNT));
   assign commit = cmd.ins_commit && !reject;
   // A bucket holds entries exactly when its valid bit is set.
   assign pos = kvalid ? SW'(bm_size_rd_ff) : '0;
   assign new_size = {1'b0, pos} + (SW+1)'(1);
   assign slot = SW'(used_ff);
   assign new_top = !top_valid_ff || (kidx >= top_key_ff);

   assign sts.blocked = !live_ff || (32'(cb_ff) < 32'(thr_ff));
   assign sts.idx_zero = (ci_ff == '0);
   assign sts.bucket_zero = (cb_ff == '0);
   assign sts.below_thr = (32'(cb_ff) < 32'(thr_ff));
   assign sts.nonempty = bv_ff[cb_ff];
   assign sts.clr_last = (clr_ff == VW'(VERTEX_IDS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_vertex = rsp_vertex_ff;
   assign rsp_bucket = rsp_bucket_ff;
   assign rsp_position = rsp_position_ff;

   always_comb begin
      clr_in = clr_ff;
      used_in = used_ff;
      bv_in = bv_ff;
      top_valid_in = top_valid_ff;
      top_key_in = top_key_ff;
      top_size_in = top_size_ff;
      top_tail_in = top_tail_ff;
      live_in = live_ff;
      cb_in = cb_ff;
      ci_in = ci_ff;
      cs_in = cs_ff;
      if (cmd.clr) begin
         clr_in = clr_ff + VW'(1);
      end
      if (commit) begin
         used_in = used_ff + (SW+1)'(1);
         bv_in[kidx] = 1'b1;
         if (new_top) begin
            top_valid_in = 1'b1;
            top_key_in = kidx;
            top_size_in = new_size;
            top_tail_in = slot;
         end
         live_in = 1'b1;
         cb_in = top_key_in;
         ci_in = SW'(top_size_in - (SW+1)'(1));
         cs_in = top_tail_in;
      end
      if (cmd.step) begin
         ci_in = ci_ff - SW'(1);
      end
      if (cmd.bucket_dec) begin
         cb_in = cb_ff - KW'(1);
      end
      if (cmd.prev_load) begin
         cs_in = sp_rd_ff;
      end
      if (cmd.scan_load) begin
         ci_in = SW'(bm_size_rd_ff - (SW+1)'(1));
         cs_in = bm_tail_rd_ff;
      end
      if (cmd.kill) begin
         live_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_position_in = rsp_position_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = bqdi_pkg::STS_NONE;
         rsp_vertex_in = '0;
         rsp_bucket_in = '0;
         rsp_position_in = '0;
         case (cmd.out_sel)
            bqdi_pkg::OUT_INSERT: begin
               rsp_vertex_in = vid_ff;
               rsp_bucket_in = key_ff;
               if (reject) begin
                  rsp_status_in = bqdi_pkg::STS_REJECTED;
               end else begin
                  rsp_status_in = bqdi_pkg::STS_INSERTED;
                  rsp_position_in = 10'(pos);
               end
            end
            bqdi_pkg::OUT_CURSOR: begin
               rsp_status_in = bqdi_pkg::STS_GIVEN;
               rsp_vertex_in = sv_rd_ff;
               rsp_bucket_in = 6'(cb_ff);
               rsp_position_in = 10'(ci_ff);
            end
            bqdi_pkg::OUT_LOOKUP: begin
               if (vid_in_range && vp_rd_ff) begin
                  rsp_status_in = bqdi_pkg::STS_GIVEN;
                  rsp_vertex_in = vid_ff;
                  rsp_bucket_in = 6'(vi_bkt_rd_ff);
                  rsp_position_in = 10'(vi_pos_rd_ff);
               end
            end
            default: begin
               rsp_status_in = bqdi_pkg::STS_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         used_ff <= '0;
         bv_ff <= '0;
         top_valid_ff <= 1'b0;
         top_key_ff <= '0;
         top_size_ff <= '0;
         top_tail_ff <= '0;
         live_ff <= 1'b0;
         cb_ff <= '0;
         ci_ff <= '0;
         cs_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         used_ff <= used_in;
         bv_ff <= bv_in;
         top_valid_ff <= top_valid_in;
         top_key_ff <= top_key_in;
         top_size_ff <= top_size_in;
         top_tail_ff <= top_tail_in;
         live_ff <= live_in;
         cb_ff <= cb_in;
         ci_ff <= ci_in;
         cs_ff <= cs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         vid_ff <= req_vertex_id;
         key_ff <= req_key;
         thr_ff <= req_threshold;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_position_ff <= rsp_position_in;
   end

   // Per-vertex stores.
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         vp_mem[clr_ff] <= 1'b0;
      end else if (commit) begin
         vp_mem[vidx] <= 1'b1;
      end
      if (cmd.vtx_rd) begin
         vp_rd_ff <= vp_mem[vidx];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         vi_bkt_mem[vidx] <= kidx;
         vi_pos_mem[vidx] <= pos;
      end
      if (cmd.vtx_rd) begin
         vi_bkt_rd_ff <= vi_bkt_mem[vidx];
         vi_pos_rd_ff <= vi_pos_mem[vidx];
      end
   end

   // Per-bucket store.
   assign bkt_addr = cmd.bkt_rd_scan ? cb_ff : kidx;

   always_ff @(posedge clock) begin
      if (commit) begin
         bm_size_mem[kidx] <= new_size;
         bm_tail_mem[kidx] <= slot;
      end
      if (cmd.bkt_rd_key || cmd.bkt_rd_scan) begin
         bm_size_rd_ff <= bm_size_mem[bkt_addr];
         bm_tail_rd_ff <= bm_tail_mem[bkt_addr];
      end
   end

   // Slot stores.
   always_comb begin
      sv_re = cmd.prev_load || cmd.scan_load || cmd.cur_rd;
      if (cmd.prev_load) begin
         sv_addr = sp_rd_ff;
      end else if (cmd.scan_load) begin
         sv_addr = bm_tail_rd_ff;
      end else begin
         sv_addr = cs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         sv_mem[slot] <= vid_ff;
      end
      if (sv_re) begin
         sv_rd_ff <= sv_mem[sv_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         sp_mem[slot] <= kvalid ? bm_tail_rd_ff : '0;
      end
      if (cmd.prev_rd) begin
         sp_rd_ff <= sp_mem[cs_ff];
      end
   end

endmodule

### rtl/bucket_queue_descending_iterator_top.sv
// Bucket queue of vertex ids keyed by a small key, with a descending cursor.
// The request channel (req) carries one transaction per operation: insert,
// get next, get current or look up vertex. The response channel (rsp)
// returns exactly one transaction for each request, in order. Both use a
// valid/ready handshake; a transaction moves when valid and ready are high.
// The key_limit register sits at address 0 of the APB-style port.
// One request is worked on at a time, and the next one is accepted the cycle
// after the response is loaded. Insert and look up read the per-vertex
// stores, insert also the bucket store, and get current the cursor vertex.
// A get next within its bucket reads the older-neighbor link, then its
// vertex; one that moves down examines lower buckets, one bucket per cycle
// through the bucket valid bits, then reads the bucket store and vertex. A
// get or get next with nothing to serve loads its response directly, or when
// a scan runs out. After reset the block sweeps all VERTEX_IDS placed flags
// (1024 by default), one per cycle, before it raises req.ready.
// When the receiver stalls, the finished result waits in the output
// register and the block holds the next operation before its final step.
module bucket_queue_descending_iterator_top #(
   parameter int SLOT_COUNT = bqdi_pkg::SLOT_COUNT_DEF,
   parameter int KEY_COUNT  = bqdi_pkg::KEY_COUNT_DEF,
   parameter int VERTEX_IDS = bqdi_pkg::VERTEX_IDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bqdi_req_if.sink    req,
   bqdi_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   bqdi_pkg::cmd_type cmd;
   bqdi_pkg::sts_type sts;
   logic [5:0] key_limit_ff, key_limit_in;
   logic       csr_write;

   // Configuration register. The upper address bit selects a word beyond
   // the register list, which reads as zero and ignores writes.
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign key_limit_in = csr_write ? pwdata[5:0] : key_limit_ff;
   assign prdata = (paddr[2] == 1'b0) ? {26'd0, key_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_limit_ff <= bqdi_pkg::KEY_LIMIT_RESET;
      end else begin
         key_limit_ff <= key_limit_in;
      end
   end

   // The sequencer decides the order of memory accesses; the datapath
   // holds the queue, the cursor and the result register.
   bqdi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (req.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   bqdi_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .KEY_COUNT  (KEY_COUNT),
      .VERTEX_IDS (VERTEX_IDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .key_limit        (key_limit_ff),
      .req_vertex_id    (req.vertex_id),
      .req_key          (req.key),
      .req_threshold    (req.threshold),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_status       (rsp.status),
      .rsp_found_vertex (rsp.found_vertex),
      .rsp_bucket       (rsp.bucket),
      .rsp_position     (rsp.position)
   );

`ifndef NO_ASSERTIONS
   // Only one transaction is in flight: the cycle after an acceptance the
   // block is busy with it.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while another is in flight");

   // A "nothing" response carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == bqdi_pkg::STS_NONE) |->
      (rsp.found_vertex == 10'd0) && (rsp.bucket == 6'd0) && (rsp.position == 10'd0))
      else $error("empty response with nonzero fields");

   // Every response is loaded while the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("response register overwritten");
`endif

endmodule
